// ----- design/tgls_pkg.sv -----
`default_nettype none

package tgls_pkg;

	localparam int NodeMax  = 16;
	localparam int NodeW    = 4;
	localparam int MaskW    = 16;
	localparam int LevelW   = 4;
	localparam int CountW   = 5;
	localparam int AddCntW  = 8;

	localparam logic [AddCntW-1:0] AddCntMax = '1;

	localparam logic ModeAdd     = 1'b0;
	localparam logic ModeCompile = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} tgls_state_t;

	typedef struct packed {
		logic add;
		logic start;
		logic emit_node;
		logic advance;
		logic emit_status;
	} tgls_cmd_t;

	typedef struct packed {
		logic cur_empty;
		logic next_empty;
		logic count_full;
		logic slot_free;
	} tgls_sts_t;

endpackage

`default_nettype wire

// ----- design/tgls_ctrl.sv -----
`default_nettype none

module tgls_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              mode,
	input  wire tgls_pkg::tgls_sts_t sts,
	output logic                   req_stall,
	output tgls_pkg::tgls_cmd_t    cmd
);
	import tgls_pkg::*;

	tgls_state_t state_q;
	tgls_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (mode == ModeAdd) begin
						cmd.add = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				priority if (!sts.cur_empty && !sts.count_full) begin
					cmd.emit_node = sts.slot_free;
				end else if (!sts.next_empty && !sts.count_full) begin
					cmd.advance = 1'b1;
				end else begin
					if (sts.slot_free) begin
						cmd.emit_status = 1'b1;
						state_d         = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/tgls_dp.sv -----
`default_nettype none

module tgls_dp #(
	parameter int MAX_NODES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tgls_pkg::tgls_cmd_t           cmd,
	output tgls_pkg::tgls_sts_t                sts,
	input  wire logic [tgls_pkg::NodeW-1:0]    node_id,
	input  wire logic [tgls_pkg::MaskW-1:0]    pred_mask,
	input  wire logic                          rsp_stall,
	output logic                               rsp_valid,
	output logic                               is_status,
	output logic [tgls_pkg::NodeW-1:0]         sched_node,
	output logic [tgls_pkg::LevelW-1:0]        level,
	output logic                               cycle_error,
	output logic [tgls_pkg::CountW-1:0]        node_count,
	output logic                               last
);
	import tgls_pkg::*;

	localparam int NodeLimit = (MAX_NODES < NodeMax) ? MAX_NODES : NodeMax;
	localparam int IdxW      = (NodeLimit > 1) ? $clog2(NodeLimit) : 1;

	logic [NodeLimit-1:0] present_q;
	logic [NodeLimit-1:0] pend_q [NodeLimit];
	logic [NodeLimit-1:0] succ_q [NodeLimit];
	logic [NodeLimit-1:0] ready_q;
	logic [AddCntW-1:0]   add_cnt_q;
	logic [NodeLimit-1:0] cur_q;
	logic [NodeLimit-1:0] next_q;
	logic [LevelW-1:0]    level_q;
	logic [CountW-1:0]    count_q;
	logic                 rsp_valid_q;

	logic                 id_ok;
	logic [IdxW-1:0]      add_idx;
	logic [NodeLimit-1:0] add_mask;
	logic [NodeLimit-1:0] add_bit;
	logic [NodeLimit-1:0] present_new;
	logic [IdxW-1:0]      sel_idx;
	logic [NodeLimit-1:0] sel_bit;
	logic [NodeLimit-1:0] sel_row;
	logic [NodeLimit-1:0] clr;
	logic [NodeLimit-1:0] wake;
	logic [NodeLimit-1:0] pend_clr [NodeLimit];
	logic                 err;

	assign id_ok       = (CountW'(node_id) < CountW'(NodeLimit));
	assign add_idx     = node_id[IdxW-1:0];
	assign add_mask    = pred_mask[NodeLimit-1:0];
	assign add_bit     = NodeLimit'(1) << add_idx;
	assign present_new = present_q | add_bit;

	// lowest set bit of the current level
	always_comb begin
		sel_idx = '0;
		for (int i = NodeLimit - 1; i >= 0; i--) begin
			if (cur_q[i]) begin
				sel_idx = IdxW'(i);
			end
		end
	end

	assign sel_bit = NodeLimit'(1) << sel_idx;
	assign sel_row = succ_q[sel_idx];

	always_comb begin
		for (int s = 0; s < NodeLimit; s++) begin
			pend_clr[s] = pend_q[s] & ~sel_bit;
			clr[s]      = sel_row[s] && pend_q[s][sel_idx];
			wake[s]     = clr[s] && (pend_clr[s] == '0);
		end
	end

	assign err = (count_q != '0) && (AddCntW'(count_q) != add_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			ready_q   <= '0;
			add_cnt_q <= '0;
			cur_q     <= '0;
			next_q    <= '0;
			level_q   <= '0;
			count_q   <= '0;
			for (int r = 0; r < NodeLimit; r++) begin
				pend_q[r] <= '0;
				succ_q[r] <= '0;
			end
		end else begin
			if (cmd.add && id_ok) begin
				if (add_cnt_q != AddCntMax) begin
					add_cnt_q <= add_cnt_q + AddCntW'(1);
				end
				present_q       <= present_new;
				pend_q[add_idx] <= add_mask;
				for (int p = 0; p < NodeLimit; p++) begin
					if (add_mask[p] && present_new[p]) begin
						succ_q[p] <= succ_q[p] | add_bit;
					end
				end
				if (add_mask == '0) begin
					ready_q <= ready_q | add_bit;
				end else begin
					ready_q <= ready_q & ~add_bit;
				end
			end
			if (cmd.start) begin
				cur_q   <= ready_q;
				ready_q <= '0;
				next_q  <= '0;
				level_q <= '0;
				count_q <= '0;
			end
			if (cmd.emit_node) begin
				cur_q   <= cur_q & ~sel_bit;
				next_q  <= next_q | wake;
				count_q <= count_q + CountW'(1);
				for (int s = 0; s < NodeLimit; s++) begin
					if (clr[s]) begin
						pend_q[s] <= pend_clr[s];
					end
				end
			end
			if (cmd.advance) begin
				cur_q   <= next_q;
				next_q  <= '0;
				level_q <= level_q + LevelW'(1);
			end
			if (cmd.emit_status) begin
				add_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit_node || cmd.emit_status) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_node) begin
			is_status   <= 1'b0;
			sched_node  <= NodeW'(sel_idx);
			level       <= level_q;
			cycle_error <= 1'b0;
			node_count  <= '0;
			last        <= 1'b0;
		end else if (cmd.emit_status) begin
			is_status   <= 1'b1;
			sched_node  <= '0;
			level       <= '0;
			cycle_error <= err;
			node_count  <= count_q;
			last        <= 1'b1;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign sts.cur_empty  = (cur_q == '0);
	assign sts.next_empty = (next_q == '0);
	assign sts.count_full = (count_q == CountW'(NodeMax));
	assign sts.slot_free  = !rsp_valid_q || !rsp_stall;

endmodule

`default_nettype wire

// ----- design/task_graph_level_scheduler.sv -----
// channel  handshake            payload
// req      req_valid/req_stall  mode, node_id, pred_mask
// rsp      rsp_valid/rsp_stall  is_status, sched_node, level, cycle_error, node_count, last
//
// Add item: recorded in the graph. Compile item: loads the ready set, emits each scheduled node,
// steps once per level change and ends with the status item, paced by the single successor-row
// read port walking one node a cycle while the output register is free to take it.
// Reset clears all graph state at once; no item is refused after reset.
// A one-entry output register holds each result; rsp_stall pauses the walk.
`default_nettype none

module task_graph_level_scheduler #(
	parameter int MAX_NODES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic                          mode,
	input  wire logic [tgls_pkg::NodeW-1:0]    node_id,
	input  wire logic [tgls_pkg::MaskW-1:0]    pred_mask,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic                               is_status,
	output logic [tgls_pkg::NodeW-1:0]         sched_node,
	output logic [tgls_pkg::LevelW-1:0]        level,
	output logic                               cycle_error,
	output logic [tgls_pkg::CountW-1:0]        node_count,
	output logic                               last
);
	import tgls_pkg::*;

	tgls_cmd_t cmd;
	tgls_sts_t sts;

	tgls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.mode      (mode),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	tgls_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.node_id     (node_id),
		.pred_mask   (pred_mask),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.is_status   (is_status),
		.sched_node  (sched_node),
		.level       (level),
		.cycle_error (cycle_error),
		.node_count  (node_count),
		.last        (last)
	);

`ifndef SYNTHESIS
	a_node_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !is_status |-> !last && !cycle_error && (node_count == '0))
		else $error("node item carries status fields");

	a_node_during_compile: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !is_status |-> req_stall)
		else $error("node item outside a compile run");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_status |-> node_count <= CountW'(NodeMax))
		else $error("node count exceeds node set");
`endif

endmodule

`default_nettype wire

// ----- test/tgls_schedule_check.sv -----
`default_nettype none

module tgls_schedule_check (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	input  wire logic                          req_stall,
	input  wire logic                          mode,
	input  wire logic [tgls_pkg::NodeW-1:0]    node_id,
	input  wire logic [tgls_pkg::MaskW-1:0]    pred_mask,
	input  wire logic                          rsp_valid,
	input  wire logic                          rsp_stall,
	input  wire logic                          is_status,
	input  wire logic [tgls_pkg::NodeW-1:0]    sched_node,
	input  wire logic [tgls_pkg::LevelW-1:0]   level,
	input  wire logic                          cycle_error,
	input  wire logic [tgls_pkg::CountW-1:0]   node_count,
	input  wire logic                          last,
	output int                                 fail_count,
	output int                                 results_due
);

	timeunit 1ns;
	timeprecision 1ps;

	import tgls_pkg::*;

	typedef struct packed {
		logic              is_status;
		logic [NodeW-1:0]  node;
		logic [LevelW-1:0] lvl;
		logic              err;
		logic [CountW-1:0] cnt;
		logic              last;
	} sched_entry_t;

	logic [MaskW-1:0]   present_nodes = '0;
	logic [MaskW-1:0]   waiting_on [NodeMax];
	logic [MaskW-1:0]   succ_rows [NodeMax];
	logic [MaskW-1:0]   ready_nodes = '0;
	logic [AddCntW-1:0] adds_seen = '0;

	sched_entry_t schedule_q [$];
	int mismatches = 0;
	int due = 0;

	assign fail_count  = mismatches;
	assign results_due = due;

	function automatic void add_node(logic [NodeW-1:0] id, logic [MaskW-1:0] mask);
		int p;
		if (adds_seen != AddCntMax)
			adds_seen = adds_seen + 1'b1;
		present_nodes[id] = 1'b1;
		waiting_on[id] = mask;
		for (p = 0; p < NodeMax; p++) begin
			if (mask[p] && present_nodes[p])
				succ_rows[p][id] = 1'b1;
		end
		ready_nodes[id] = (mask == '0);
	endfunction

	// Kahn walk, one wave per level, ascending index within a wave.
	function automatic void compile_schedule();
		logic [MaskW-1:0] wave;
		logic [MaskW-1:0] next_wave;
		int lvl;
		int emitted;
		int n;
		int s;
		sched_entry_t e;
		wave = ready_nodes;
		ready_nodes = '0;
		lvl = 0;
		emitted = 0;
		while (wave != '0 && emitted < NodeMax) begin
			next_wave = '0;
			for (n = 0; n < NodeMax; n++) begin
				if (wave[n] && emitted < NodeMax) begin
					e = '0;
					e.node = NodeW'(n);
					e.lvl = LevelW'(lvl);
					schedule_q.insert(schedule_q.size(), e);
					emitted++;
					for (s = 0; s < NodeMax; s++) begin
						if (succ_rows[n][s] && waiting_on[s][n]) begin
							waiting_on[s][n] = 1'b0;
							if (waiting_on[s] == '0)
								next_wave[s] = 1'b1;
						end
					end
				end
			end
			wave = next_wave;
			lvl++;
		end
		e = '0;
		e.is_status = 1'b1;
		e.err = (emitted != 0) && (emitted != int'(adds_seen));
		e.cnt = CountW'(emitted);
		e.last = 1'b1;
		schedule_q.insert(schedule_q.size(), e);
		adds_seen = '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_entry_t got;
		sched_entry_t want;
		int i;
		if (!arst_n) begin
			present_nodes = '0;
			ready_nodes = '0;
			adds_seen = '0;
			for (i = 0; i < NodeMax; i++) begin
				waiting_on[i] = '0;
				succ_rows[i] = '0;
			end
			schedule_q.delete();
			due = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got = {is_status, sched_node, level, cycle_error, node_count, last};
				if (schedule_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: st=%0d node=%0d lvl=%0d err=%0d cnt=%0d last=%0d",
							got.is_status, got.node, got.lvl, got.err, got.cnt, got.last);
				end else begin
					want = schedule_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp st=%0d node=%0d lvl=%0d err=%0d cnt=%0d last=%0d",
								" got st=%0d node=%0d lvl=%0d err=%0d cnt=%0d last=%0d"},
								want.is_status, want.node, want.lvl, want.err, want.cnt,
								want.last, got.is_status, got.node, got.lvl, got.err,
								got.cnt, got.last);
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (mode == ModeCompile)
					compile_schedule();
				else
					add_node(node_id, pred_mask);
			end
			due = schedule_q.size();
		end
	end

endmodule

`default_nettype wire

// ----- test/task_graph_level_scheduler_test.sv -----
`default_nettype none

module task_graph_level_scheduler_test;

	timeunit 1ns;
	timeprecision 1ps;

	import tgls_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic              mode = ModeAdd;
	logic [NodeW-1:0]  node_id = '0;
	logic [MaskW-1:0]  pred_mask = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic              is_status;
	logic [NodeW-1:0]  sched_node;
	logic [LevelW-1:0] level;
	logic              cycle_error;
	logic [CountW-1:0] node_count;
	logic              last;

	int fail_count;
	int results_due;
	int send_idle = 28;
	int recv_idle = 69;
	int hold_left = 0;
	int items_sent = 0;

	task_graph_level_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.mode(mode), .node_id(node_id), .pred_mask(pred_mask),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.is_status(is_status), .sched_node(sched_node), .level(level),
		.cycle_error(cycle_error), .node_count(node_count), .last(last)
	);

	tgls_schedule_check sched_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.mode(mode), .node_id(node_id), .pred_mask(pred_mask),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.is_status(is_status), .sched_node(sched_node), .level(level),
		.cycle_error(cycle_error), .node_count(node_count), .last(last),
		.fail_count(fail_count), .results_due(results_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("task_graph_level_scheduler_test failed");
		$finish;
	end

	// receiver: random stall, or a counted hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	task automatic offer(input logic m, input int unsigned id, input logic [MaskW-1:0] mask);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		mode <= m;
		node_id <= NodeW'(id);
		pred_mask <= mask;
		do
			@(posedge clk);
		while (req_stall);
		items_sent++;
	endtask

	task automatic random_round();
		int sel;
		int k;
		int i;
		int j;
		int tmp;
		int order [NodeMax];
		logic [MaskW-1:0] mask;
		sel = $urandom_range(99);
		if (sel < 70) begin
			// mostly well-formed graph: preds drawn from nodes added earlier in the batch, with an occasional random pred
			for (i = 0; i < NodeMax; i++)
				order[i] = i;
			for (i = NodeMax - 1; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
			k = $urandom_range(NodeMax, 1);
			for (j = 0; j < k; j++) begin
				mask = '0;
				for (i = 0; i < j; i++) begin
					if ($urandom_range(99) < 40)
						mask[order[i]] = 1'b1;
				end
				if ($urandom_range(99) < 8)
					mask[$urandom_range(NodeMax - 1)] = 1'b1;
				offer(ModeAdd, order[j], mask);
			end
			if ($urandom_range(99) < 15)
				offer(ModeAdd, order[0], '0);
			offer(ModeCompile, $urandom_range(NodeMax - 1), MaskW'($urandom));
		end else if (sel < 90) begin
			repeat ($urandom_range(4, 1))
				offer(ModeAdd, $urandom_range(NodeMax - 1), MaskW'($urandom));
		end else begin
			offer(ModeCompile, $urandom_range(NodeMax - 1), MaskW'($urandom));
		end
	endtask

	initial begin
		int ph;
		int i;
		int target;
		int guard;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty graph
		offer(ModeCompile, 0, '0);
		// dangling pred, self dependency, re-add
		offer(ModeAdd, 4, 16'h0020);
		offer(ModeAdd, 6, 16'h0040);
		offer(ModeAdd, 9, '0);
		offer(ModeAdd, 9, '0);
		offer(ModeCompile, 15, '1);
		// full chain: 16 nodes, levels 0..15
		offer(ModeAdd, 0, '0);
		for (i = 1; i < NodeMax; i++)
			offer(ModeAdd, i, MaskW'(1) << (i - 1));
		offer(ModeCompile, 0, '0);
		// repeated re-adds of one node
		repeat (4)
			offer(ModeAdd, 10, '1);
		offer(ModeAdd, 11, '0);
		offer(ModeAdd, 12, '0);
		offer(ModeCompile, 0, '0);

		target = items_sent;
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 28;
					recv_idle = 69;
				end
				1: begin
					send_idle = 69;
					recv_idle = 28;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
					hold_left = 150;
				end
			endcase
			target = target + 73;
			while (items_sent < target)
				random_round();
			if (ph == 1) begin
				req_valid <= 1'b0;
				do
					@(posedge clk);
				while (results_due != 0);
			end
		end

		req_valid <= 1'b0;
		guard = 0;
		while (results_due != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
		if (fail_count == 0 && results_due == 0)
			$display("task_graph_level_scheduler_test passed");
		else
			$display("task_graph_level_scheduler_test failed");
		$finish;
	end

endmodule

`default_nettype wire
